[hw/rtl/qkas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkas_pkg
// shared types and constants for the accelerated quadrature knob step block
// ----------------------------------------------------------------------------
package qkas_pkg;

    // quadrature tracker states
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_INC0 = 4'd1,
        PH_INC1 = 4'd2,
        PH_INC2 = 4'd3,
        PH_DEC0 = 4'd4,
        PH_DEC1 = 4'd5,
        PH_DEC2 = 4'd6,
        PH_A0B0 = 4'd7,
        PH_A0B1 = 4'd8,
        PH_A1B0 = 4'd9
    } t_phase;

    // read sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MIN,
        S_OUT
    } t_state;

    // configuration register indexes
    localparam logic [1:0] CFG_LOWER = 2'd0;
    localparam logic [1:0] CFG_UPPER = 2'd1;
    localparam logic [1:0] CFG_RATE  = 2'd2;

    // item kinds on the input stream
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam int MIN_TICKS   = 32;
    localparam int SPEED_SHIFT = 6;
    localparam int PULSE_W     = 8;
    localparam int DVD_W       = PULSE_W + SPEED_SHIFT;

    typedef struct packed {
        logic sample;
        logic chan_a;
        logic chan_b;
        logic clr_all;
        logic clr_cnt;
    } t_trk_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hw/rtl/qkas_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkas_tracker
// ten-state quadrature tracker with saturating tick, pulse and loss counters
// ----------------------------------------------------------------------------
module qkas_tracker
    import qkas_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_trk_ctrl                 i_ctrl,
    output logic [15:0]               o_tick,
    output logic signed [PULSE_W-1:0] o_pulse,
    output logic [7:0]                o_loss
);

    t_phase                    r_phase, n_phase;
    logic [15:0]               r_tick, n_tick;
    logic signed [PULSE_W-1:0] r_pulse, n_pulse;
    logic [7:0]                r_loss, n_loss;
    logic                      w_up, w_dn, w_lose;

    always_comb begin
        n_phase = r_phase;
        w_up    = 1'b0;
        w_dn    = 1'b0;
        w_lose  = 1'b0;
        case ({i_ctrl.chan_a, i_ctrl.chan_b})
            2'b11: begin
                case (r_phase)
                    PH_INC1, PH_INC2: w_up = 1'b1;
                    PH_DEC1, PH_DEC2: w_dn = 1'b1;
                    PH_IDLE:          ;
                    default:          w_lose = 1'b1;
                endcase
                n_phase = PH_IDLE;
            end
            2'b01: begin
                case (r_phase)
                    PH_IDLE:                   n_phase = PH_INC0;
                    PH_INC2: begin
                        n_phase = PH_INC0;
                        w_up    = 1'b1;
                    end
                    PH_DEC0, PH_DEC1, PH_A0B0: n_phase = PH_DEC2;
                    PH_INC0, PH_DEC2:          ;
                    default:                   n_phase = PH_A0B1;
                endcase
            end
            2'b10: begin
                case (r_phase)
                    PH_IDLE:                   n_phase = PH_DEC0;
                    PH_DEC2: begin
                        n_phase = PH_DEC0;
                        w_dn    = 1'b1;
                    end
                    PH_INC0, PH_INC1, PH_A0B0: n_phase = PH_INC2;
                    PH_DEC0, PH_INC2:          ;
                    default:                   n_phase = PH_A1B0;
                endcase
            end
            default: begin
                case (r_phase)
                    PH_INC0, PH_A0B1: n_phase = PH_INC1;
                    PH_DEC0, PH_A1B0: n_phase = PH_DEC1;
                    PH_DEC1, PH_INC1: ;
                    default:          n_phase = PH_A0B0;
                endcase
            end
        endcase

        n_tick  = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;
        n_pulse = r_pulse;
        if (w_up && r_pulse != 8'sd127) begin
            n_pulse = r_pulse + 8'sd1;
        end else if (w_dn && r_pulse != -8'sd128) begin
            n_pulse = r_pulse - 8'sd1;
        end
        n_loss = (w_lose && r_loss != 8'hFF) ? r_loss + 8'd1 : r_loss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr_all) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_pulse <= '0;
            r_loss  <= '0;
        end else if (i_ctrl.clr_cnt) begin
            r_tick  <= '0;
            r_pulse <= '0;
            r_loss  <= '0;
        end else if (i_ctrl.sample) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_pulse <= n_pulse;
            r_loss  <= n_loss;
        end
    end

    assign o_tick  = r_tick;
    assign o_pulse = r_pulse;
    assign o_loss  = r_loss;

endmodule

[hw/rtl/qkas_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qkas_divider
// restoring divider, one quotient bit per cycle through one shared subtractor
// ----------------------------------------------------------------------------
module qkas_divider
    import qkas_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [15:0]      i_divisor,
    output t_div_stat        o_stat,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] r_dvd;
    logic [15:0]      r_rem;
    logic [15:0]      r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [16:0]      w_shift;
    logic [16:0]      w_diff;
    logic             w_ge;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // payload: remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[15:0] : w_shift[15:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_dvd;

endmodule

[hw/rtl/quadrature_knob_accelerated_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_knob_accelerated_step
// quadrature knob decoder producing speed-scaled, limit-clamped steps
// ----------------------------------------------------------------------------
// usage:
//   input stream s_axis: tuser = cmd (0 sample, 1 read). a sample transfer
//   carries the A/B levels and advances the tracker; it yields no result. a
//   read transfer carries current_value and yields one
//   result on m_axis: step_value and lost_sequences.
//   a read passes from its transfer to the result being loaded through:
//   the accept, the restoring divider (one quotient bit per cycle), the
//   rate multiply registered with the quotient, the headroom minimum in
//   S_MIN and the output register load in S_OUT. a read with fewer
//   than 32 ticks gathered skips the divider and goes straight to S_OUT.
//   s_axis_tready is low while a read is in flight.
//   results sit in an output register; while the receiver stalls, samples
//   keep being accepted, and a following read waits in its final cycle
//   until the register is free.
//   config writes (index 0 lower, 1 upper, 2 rate) take effect at once and
//   clear the tracker counters and phase; other indexes are ignored.
//   reset (synchronous, active low) restores limits 0/65535, rate 1 and
//   clears the tracker and the output valid flag.
// ----------------------------------------------------------------------------
module quadrature_knob_accelerated_step
    import qkas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [0] chan_a, [1] chan_b, [17:2] current_value
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] step_value, [23:16] lost_sequences
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_lower;
    logic [15:0] r_upper;
    logic [7:0]  r_rate;

    // sequencer
    t_state      r_state, n_state;
    logic        r_early;
    logic        r_pos;
    logic [15:0] r_cur;
    logic [15:0] r_mag;
    logic signed [17:0] r_mn;

    // output register
    logic        r_out_valid;
    logic [23:0] r_out_data;

    // tracker and divider hookup
    t_trk_ctrl                 w_trk;
    logic [15:0]               w_tick;
    logic signed [PULSE_W-1:0] w_pulse;
    logic [7:0]                w_loss;
    t_div_stat                 w_div_stat;
    logic [DVD_W-1:0]          w_quot;

    logic        w_in_fire;
    logic        w_is_read;
    logic        w_cfg_hit;
    logic        w_early;
    logic        w_div_start;
    logic        w_load;
    logic [7:0]  w_p;
    logic [8:0]  w_max;
    logic [16:0] w_prod;
    logic [15:0] w_mag;
    logic signed [17:0] w_room;
    logic signed [17:0] w_mag_s;
    logic signed [17:0] w_mn;
    logic signed [17:0] w_stp;
    logic [15:0] w_step;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_is_read     = (s_axis_tuser[0] == CMD_READ);
    assign w_cfg_hit     = i_cfg_valid && (i_cfg_index inside {CFG_LOWER, CFG_UPPER, CFG_RATE});

    // counters are frozen while a read is in flight unless a config write clears them, so they serve as the snapshot
    assign w_early     = (w_tick < 16'(MIN_TICKS));
    assign w_p         = w_pulse[PULSE_W-1] ? (~w_pulse + 8'd1) : w_pulse;
    assign w_div_start = w_in_fire && w_is_read && !w_early;
    assign w_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    assign w_trk.sample  = w_in_fire && !w_is_read;
    assign w_trk.chan_a  = s_axis_tdata[0];
    assign w_trk.chan_b  = s_axis_tdata[1];
    assign w_trk.clr_all = w_cfg_hit;
    assign w_trk.clr_cnt = w_load && !r_early;

    qkas_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_trk),
        .o_tick  (w_tick),
        .o_pulse (w_pulse),
        .o_loss  (w_loss)
    );

    qkas_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_p, SPEED_SHIFT'(0)}),
        .i_divisor  (w_tick),
        .o_stat     (w_div_stat),
        .o_quotient (w_quot)
    );

    // speed: quotient never exceeds 256 since ticks >= 32 and pulses <= 128
    assign w_max  = (w_quot[8:0] < {1'b0, w_p}) ? {1'b0, w_p} : w_quot[8:0];
    assign w_prod = {8'd0, w_max} * {9'd0, r_rate};
    always_comb begin
        if (w_p == 8'd1) begin
            w_mag = 16'd1;
        end else if (w_max != {1'b0, w_p}) begin
            w_mag = w_prod[15:0];
        end else begin
            w_mag = {7'd0, w_max};
        end
    end

    // headroom toward the limit in the turning direction, may be negative
    assign w_room  = r_pos ? ($signed({2'b00, r_upper}) - $signed({2'b00, r_cur}))
                           : ($signed({2'b00, r_cur}) - $signed({2'b00, r_lower}));
    assign w_mag_s = $signed({2'b00, r_mag});
    assign w_mn    = (w_room > w_mag_s) ? w_mag_s : w_room;

    // sign and saturate to 16 bits
    assign w_stp = r_pos ? r_mn : -r_mn;
    always_comb begin
        if (r_early) begin
            w_step = 16'd0;
        end else if (w_stp > 18'sd32767) begin
            w_step = 16'h7FFF;
        end else if (w_stp < -18'sd32768) begin
            w_step = 16'h8000;
        end else begin
            w_step = w_stp[15:0];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire && w_is_read) begin
                    n_state = w_early ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = S_MIN;
                end
            end
            S_MIN:   n_state = S_OUT;
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // read payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_is_read) begin
            r_early <= w_early;
            r_pos   <= !w_pulse[PULSE_W-1] && (w_pulse != '0);
            r_cur   <= s_axis_tdata[17:2];
        end
        if (r_state == S_DIV && w_div_stat.done) begin
            r_mag <= w_mag;
        end
        if (r_state == S_MIN) begin
            r_mn <= w_mn;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= 16'd0;
            r_upper <= 16'hFFFF;
            r_rate  <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_RATE:  r_rate  <= i_cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {w_loss, w_step};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // checks
    a_div_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> r_state == S_DIV)
        else $error("divider busy outside divide state");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> w_quot <= DVD_W'(256))
        else $error("speed quotient out of range");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_early) |=> (w_tick == '0 && w_pulse == '0 && w_loss == '0))
        else $error("counters not cleared after read");

    a_loss_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tdata[23:16] == $past(w_loss))
        else $error("reported loss count mismatch");

endmodule
